// File: hw/rtl/c1conv_pkg.sv
// Shared constants, codes and handshake structs for the 5x5 six-map tanh layer.
// Used by the serial divider and the layer core; depends on nothing else.
`default_nettype none

package c1conv_pkg;

  // default geometry of the layer
  localparam int IMAGE_SIDE_DEF   = 32;
  localparam int KERNEL_SIDE_DEF  = 5;
  localparam int FILTER_COUNT_DEF = 6;

  // fixed field widths
  localparam int SB        = 16;  // sample bits, Q3.12
  localparam int MAP_SLOTS = 6;   // map fields on the result
  localparam int POS_W     = 5;   // out_row / out_col width
  localparam int ACC_W     = 40;  // Q.24 accumulator, holds 25 taps plus bias

  // serial divider geometry
  localparam int DIV_W  = 48;     // dividend / quotient shift register
  localparam int DEN_W  = 34;     // divisor and partial remainder
  localparam int STEP_W = 6;

  localparam logic [STEP_W-1:0] STEPS_TERM   = 6'd32;  // series term / n
  localparam logic [STEP_W-1:0] STEPS_RESULT = 6'd47;  // final quotient

  localparam logic [31:0]      LN2_Q32   = 32'd2977044472;
  localparam logic [DEN_W-1:0] ONE_Q32   = 34'h1_0000_0000;
  localparam logic [ACC_W-1:0] SAT_Q24   = 40'd6 << 24;
  localparam logic [15:0]      Q14_ONE   = 16'd16384;
  localparam logic [3:0]       LAST_TERM = 4'd14;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_PIXEL  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;  // left aligned
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/conv5x5_six_map_tanh_layer_core.sv
// Six-filter valid 5x5 convolution with tanh activation over a raster-order
// image. A load transaction (weight, bias or unknown command) leaves the
// sequencer idle; a pixel that completes no window only shifts the window. A
// pixel that completes a window runs every filter in turn through one shared
// multiplier and one serial divider: multiply-accumulate over KERNEL_SIDE^2
// taps, then for a sum below saturation range reduction by repeated
// subtraction of ln2, 13 series terms and a final quotient (a saturated
// filter needs only the multiply-accumulate, the abs check and the store).
// The serial divider produces one quotient bit per cycle.
// Input is stalled while a pixel is in work; a finished result waits in the
// output register while the next transaction is taken.
`default_nettype none

module conv5x5_six_map_tanh_layer_core #(
  parameter int IMAGE_SIDE   = c1conv_pkg::IMAGE_SIDE_DEF,
  parameter int KERNEL_SIDE  = c1conv_pkg::KERNEL_SIDE_DEF,
  parameter int FILTER_COUNT = c1conv_pkg::FILTER_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  command,
  input  wire logic [7:0]                  slot,
  input  wire logic signed [15:0]          value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [c1conv_pkg::POS_W-1:0]     out_row,
  output logic [c1conv_pkg::POS_W-1:0]     out_col,
  output logic signed [15:0]               map_zero,
  output logic signed [15:0]               map_one,
  output logic signed [15:0]               map_two,
  output logic signed [15:0]               map_three,
  output logic signed [15:0]               map_four,
  output logic signed [15:0]               map_five,
  output logic                             frame_end
);
  import c1conv_pkg::*;

  localparam int TAPS   = KERNEL_SIDE * KERNEL_SIDE;
  localparam int TAP_W  = $clog2(TAPS);
  localparam int TCNT_W = $clog2(TAPS + 1);
  localparam int WCOUNT = FILTER_COUNT * TAPS;
  localparam int WA_W   = $clog2(WCOUNT);
  localparam int FI_W   = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
  localparam int COL_W  = $clog2(IMAGE_SIDE);
  localparam int ROWS   = KERNEL_SIDE - 1;
  localparam int LINE_W = ROWS * SB;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SHIFT  = 13'b0000000000010,
    S_MAC    = 13'b0000000000100,
    S_ABS    = 13'b0000000001000,
    S_DIVK   = 13'b0000000010000,
    S_EMUL   = 13'b0000000100000,
    S_ESTART = 13'b0000001000000,
    S_EWAIT  = 13'b0000010000000,
    S_EFIN   = 13'b0000100000000,
    S_ENUM   = 13'b0001000000000,
    S_FWAIT  = 13'b0010000000000,
    S_STORE  = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t state;

  // stores
  logic signed [SB-1:0]     weight_mem [WCOUNT];
  logic [LINE_W-1:0]        line_mem   [IMAGE_SIDE];
  logic signed [SB-1:0]     bias       [FILTER_COUNT];
  logic signed [SB-1:0]     win        [TAPS];
  logic signed [SB-1:0]     w_rd;
  logic signed [SB-1:0]     x_rd;
  logic [LINE_W-1:0]        line_rd;
  logic [LINE_W-1:0]        line_new;
  logic signed [SB-1:0]     pix;

  logic [COL_W-1:0]         pixel_row;
  logic [COL_W-1:0]         pixel_col;
  logic [POS_W-1:0]         res_row;
  logic [POS_W-1:0]         res_col;
  logic                     res_last;
  logic                     win_ready;

  // multiply-accumulate
  logic [TCNT_W-1:0]        tap;
  logic [WA_W-1:0]          wa;
  logic [FI_W-1:0]          filter;
  logic                     v1;
  logic                     v2;
  logic signed [32:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [65:0]       prod;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         acc_abs;
  logic                     sat;

  // tanh
  logic [35:0]              yred;
  logic                     range_fit;
  logic [4:0]               k;
  logic [31:0]              r;
  logic [31:0]              term;
  logic [DEN_W-1:0]         pos;
  logic [DEN_W-1:0]         neg;
  logic [DEN_W-1:0]         exp_val;
  logic [32:0]              e_val;
  logic [32:0]              one_minus;
  logic [3:0]               n;
  logic [15:0]              mag;
  logic signed [15:0]       act [FILTER_COUNT];
  logic signed [15:0]       om  [MAP_SLOTS];

  div_req_t                 div_req;
  div_stat_t                div_stat;
  logic [DIV_W-1:0]         div_quo;

  logic                     in_take;
  logic                     out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign win_ready = (pixel_row >= COL_W'(KERNEL_SIDE - 1)) &&
                     (pixel_col >= COL_W'(KERNEL_SIDE - 1));

  assign acc_abs   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign sat       = acc_abs >= SAT_Q24;
  assign range_fit = yred >= {4'b0, LN2_Q32};
  assign exp_val   = pos - neg;
  assign one_minus = ONE_Q32[32:0] - e_val;

  // line store entry: oldest buffered row in the low bits; drop it, append pixel
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      if (i == ROWS - 1) begin
        line_new[i*SB +: SB] = pix;
      end else begin
        line_new[i*SB +: SB] = line_rd[((i + 1 < ROWS) ? i + 1 : i)*SB +: SB];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SHIFT) begin
      line_mem[pixel_col] <= line_new;
    end
    line_rd <= line_mem[pixel_col];
  end

  always_ff @(posedge clk) begin
    if (in_take && command == CMD_WEIGHT && 32'(slot) < 32'(WCOUNT)) begin
      weight_mem[WA_W'(slot)] <= value;
    end
    w_rd <= weight_mem[wa];
  end

  always_ff @(posedge clk) begin
    if (in_take && command == CMD_BIAS && 32'(slot) < 32'(FILTER_COUNT)) begin
      bias[FI_W'(slot)] <= value;
    end
  end

  // shared multiplier, registered product
  always_comb begin
    if (state == S_MAC) begin
      mul_a = 33'(x_rd);
      mul_b = 33'(w_rd);
    end else begin
      mul_a = $signed({1'b0, term});
      mul_b = $signed({1'b0, r});
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    div_req = '0;
    case (state)
      S_ESTART: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_TERM;
        div_req.dividend = {prod[63:32], 16'b0};
        div_req.divisor  = DEN_W'(n);
      end
      S_ENUM: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_RESULT;
        div_req.dividend = {one_minus[31:0], 15'b0, 1'b0};
        div_req.divisor  = ONE_Q32 + DEN_W'(e_val);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  c1conv_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat),
    .quo  (div_quo)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pixel_row <= '0;
      pixel_col <= '0;
      tap       <= '0;
      wa        <= '0;
      filter    <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        win[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take && command == CMD_PIXEL) begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          for (int i = 0; i < KERNEL_SIDE; i++) begin
            for (int j = 0; j + 1 < KERNEL_SIDE; j++) begin
              win[i*KERNEL_SIDE + j] <= win[i*KERNEL_SIDE + j + 1];
            end
          end
          for (int i = 0; i < ROWS; i++) begin
            win[i*KERNEL_SIDE + KERNEL_SIDE - 1] <= line_rd[i*SB +: SB];
          end
          win[TAPS - 1] <= pix;
          if (pixel_col == COL_W'(IMAGE_SIDE - 1)) begin
            pixel_col <= '0;
            pixel_row <= (pixel_row == COL_W'(IMAGE_SIDE - 1)) ? '0 : pixel_row + 1'b1;
          end else begin
            pixel_col <= pixel_col + 1'b1;
          end
          tap    <= '0;
          wa     <= '0;
          filter <= '0;
          v1     <= 1'b0;
          v2     <= 1'b0;
          state  <= win_ready ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          if (tap < TCNT_W'(TAPS)) begin
            tap <= tap + 1'b1;
            wa  <= wa + 1'b1;
            v1  <= 1'b1;
          end else begin
            v1 <= 1'b0;
          end
          v2 <= v1;
          if (tap == TCNT_W'(TAPS) && !v1 && !v2) begin
            state <= S_ABS;
          end
        end
        S_ABS: begin
          state <= sat ? S_STORE : S_DIVK;
        end
        S_DIVK: begin
          if (!range_fit) begin
            state <= S_EMUL;
          end
        end
        S_EMUL: begin
          state <= S_ESTART;
        end
        S_ESTART: begin
          state <= S_EWAIT;
        end
        S_EWAIT: begin
          if (div_stat.done) begin
            state <= (n == LAST_TERM) ? S_EFIN : S_EMUL;
          end
        end
        S_EFIN: begin
          state <= S_ENUM;
        end
        S_ENUM: begin
          state <= S_FWAIT;
        end
        S_FWAIT: begin
          if (div_stat.done) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          if (filter == FI_W'(FILTER_COUNT - 1)) begin
            state <= S_OUT;
          end else begin
            filter <= filter + 1'b1;
            tap    <= '0;
            v1     <= 1'b0;
            v2     <= 1'b0;
            state  <= S_MAC;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      pix <= value;
    end
    if (state == S_SHIFT) begin
      res_row  <= POS_W'(pixel_row - COL_W'(KERNEL_SIDE - 1));
      res_col  <= POS_W'(pixel_col - COL_W'(KERNEL_SIDE - 1));
      res_last <= (pixel_row == COL_W'(IMAGE_SIDE - 1)) &&
                  (pixel_col == COL_W'(IMAGE_SIDE - 1));
      acc      <= {{(ACC_W-SB-12){bias[0][SB-1]}}, bias[0], 12'b0};
    end
    if (state == S_MAC) begin
      if (tap < TCNT_W'(TAPS)) begin
        x_rd <= win[tap[TAP_W-1:0]];
      end
      if (v2) begin
        acc <= acc + prod[ACC_W-1:0];
      end
    end
    if (state == S_ABS) begin
      yred <= {acc_abs[26:0], 9'b0};
      k    <= '0;
      if (sat) begin
        mag <= Q14_ONE;
      end
    end
    // subtract ln2 until the remainder drops below it
    if (state == S_DIVK) begin
      if (range_fit) begin
        yred <= yred - {4'b0, LN2_Q32};
        k    <= k + 1'b1;
      end else begin
        r    <= yred[31:0];
        term <= yred[31:0];
        neg  <= DEN_W'(yred[31:0]);
        pos  <= ONE_Q32;
        n    <= 4'd2;
      end
    end
    if (state == S_EWAIT && div_stat.done) begin
      term <= div_quo[31:0];
      if (n[0]) begin
        neg <= neg + DEN_W'(div_quo[31:0]);
      end else begin
        pos <= pos + DEN_W'(div_quo[31:0]);
      end
      n <= n + 1'b1;
    end
    if (state == S_EFIN) begin
      e_val <= 33'(exp_val >> k);
    end
    if (state == S_FWAIT && div_stat.done) begin
      mag <= 16'((17'(div_quo[15:0]) + 17'd1) >> 1);
    end
    if (state == S_STORE) begin
      act[filter] <= acc[ACC_W-1] ? -$signed(mag) : $signed(mag);
      if (filter != FI_W'(FILTER_COUNT - 1)) begin
        acc <= {{(ACC_W-SB-12){bias[filter + 1'b1][SB-1]}}, bias[filter + 1'b1], 12'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_row   <= res_row;
      out_col   <= res_col;
      frame_end <= res_last;
    end
  end

  for (genvar g = 0; g < MAP_SLOTS; g++) begin : g_map
    if (g < FILTER_COUNT) begin : g_used
      always_ff @(posedge clk) begin
        if (state == S_OUT && out_free) begin
          om[g] <= act[g];
        end
      end
    end else begin : g_unused
      always_ff @(posedge clk) begin
        om[g] <= '0;
      end
    end
  end

  assign map_zero  = om[0];
  assign map_one   = om[1];
  assign map_two   = om[2];
  assign map_three = om[3];
  assign map_four  = om[4];
  assign map_five  = om[5];

`ifndef NO_ASSERTIONS
  a_out_from_seq : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output step");

  a_div_idle_start : assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_mac_drain : assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC && tap == TCNT_W'(TAPS) && !v1 && !v2) |=> state == S_ABS)
    else $error("accumulation left with products in flight");

  a_col_range : assert property (@(posedge clk) disable iff (rst)
    pixel_col <= COL_W'(IMAGE_SIDE - 1) && pixel_row <= COL_W'(IMAGE_SIDE - 1))
    else $error("pixel position beyond the image");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/c1conv_div.sv
// Restoring serial divider, one quotient bit per cycle, shared by the series terms and the final quotient.
// Depends on c1conv_pkg for its widths and request / status structs.
`default_nettype none

module c1conv_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire c1conv_pkg::div_req_t          req,
  output c1conv_pkg::div_stat_t              stat,
  output logic [c1conv_pkg::DIV_W-1:0]       quo
);
  import c1conv_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [DIV_W-1:0]  d;
  logic [DEN_W-1:0]  rmd;
  logic [DEN_W-1:0]  dv;
  logic [DEN_W:0]    rs;
  logic [DEN_W:0]    diff;
  logic              fits;

  assign rs   = {rmd, d[DIV_W-1]};
  assign fits = rs >= {1'b0, dv};
  assign diff = rs - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits enter at the bottom as dividend bits leave at the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      d   <= req.dividend;
      rmd <= '0;
      dv  <= req.divisor;
    end else if (busy) begin
      d   <= {d[DIV_W-2:0], fits};
      rmd <= fits ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quo       = d;

endmodule

`default_nettype wire
